>>> hdl/lux_to_brightness_piecewise_map_top_assert.svh
// Assertion macros shared by the checker of the lux to brightness block.
// Depends on nothing; included by the checker file.
`ifndef LUX_TO_BRIGHTNESS_PIECEWISE_MAP_TOP_ASSERT_SVH
`define LUX_TO_BRIGHTNESS_PIECEWISE_MAP_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define LTB_ASSERT_IMP(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define LTB_ASSERT_NXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ltb_pkg.sv
// Shared constants, types and field helpers of the lux to brightness block.
// Depends on nothing; used by every module of the block.
`default_nettype none

package ltb_pkg;

  localparam int LUX_WIDTH = 20;
  localparam int NUM_SEGS  = 5;
  localparam int SEG_W     = 3;
  localparam int BRT_W     = 8;
  localparam int CFG_W     = 2 * LUX_WIDTH + 2 * BRT_W;
  localparam int CFG_IDX_W = $clog2(NUM_SEGS);
  localparam int DIFF_W    = LUX_WIDTH + 1;
  localparam int SPAN_W    = BRT_W + 1;
  localparam int PROD_W    = LUX_WIDTH + BRT_W;

  typedef logic [CFG_W-1:0]     seg_reg_t;
  typedef seg_reg_t [NUM_SEGS-1:0] cfg_bank_t;
  typedef logic [SEG_W-1:0]     seg_idx_t;
  typedef logic [LUX_WIDTH-1:0] lux_t;
  typedef logic [BRT_W-1:0]     brt_t;

  localparam seg_idx_t LAST_SEG = seg_idx_t'(NUM_SEGS - 1);

  typedef struct packed {
    brt_t     bmin;
    brt_t     bmax;
    logic     zero_den;
    logic     capped;
    logic     neg;
    seg_idx_t seg;
  } res_tag_t;

  typedef struct packed {
    logic              valid;
    logic [PROD_W-1:0] num;
    lux_t              den;
    res_tag_t          tag;
  } div_word_t;

  function automatic lux_t seg_lo(input seg_reg_t r);
    return r[LUX_WIDTH-1:0];
  endfunction

  function automatic lux_t seg_hi(input seg_reg_t r);
    return r[2*LUX_WIDTH-1:LUX_WIDTH];
  endfunction

  function automatic brt_t seg_bmin(input seg_reg_t r);
    return r[2*LUX_WIDTH +: BRT_W];
  endfunction

  function automatic brt_t seg_bmax(input seg_reg_t r);
    return r[2*LUX_WIDTH+BRT_W +: BRT_W];
  endfunction

endpackage

`default_nettype wire

>>> hdl/ltb_cfg.sv
// Segment configuration registers, written through a plain write port.
// Depends on ltb_pkg.
`default_nettype none

module ltb_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [ltb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ltb_pkg::CFG_W-1:0]     cfg_wdata,
  output ltb_pkg::cfg_bank_t                 bank
);
  import ltb_pkg::*;

  cfg_bank_t bank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= '0;
    end else begin
      for (int i = 0; i < NUM_SEGS; i++) begin
        if (cfg_we && (cfg_index == CFG_IDX_W'(i))) begin
          bank_r[i] <= cfg_wdata;
        end
      end
    end
  end

  assign bank = bank_r;

endmodule

`default_nettype wire

>>> hdl/ltb_front.sv
// Front pipeline: clamp, segment search, operand setup and the multiply.
// Five register stages. Depends on ltb_pkg.
`default_nettype none

module ltb_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_take,
  input  wire ltb_pkg::lux_t      in_lux,
  input  wire ltb_pkg::cfg_bank_t bank,
  output ltb_pkg::div_word_t      front_o
);
  import ltb_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  lux_t                     lux_c;
  lux_t                     lux1_r;
  lux_t                     lux2_r;
  logic [NUM_SEGS-2:0]      le_c;
  logic [NUM_SEGS-2:0]      le2_r;
  seg_idx_t                 seg_c;
  seg_reg_t                 sel_c;
  logic signed [DIFF_W-1:0] num_c;
  logic signed [DIFF_W-1:0] den_c;
  seg_idx_t                 seg3_r;
  logic signed [DIFF_W-1:0] num3_r;
  logic signed [DIFF_W-1:0] den3_r;
  brt_t                     bmin3_r;
  brt_t                     bmax3_r;
  logic signed [SPAN_W-1:0] span_c;
  logic [DIFF_W-1:0]        nabs_c;
  logic [DIFF_W-1:0]        dabs_c;
  logic [SPAN_W-1:0]        sabs_c;
  res_tag_t                 tag_c;
  lux_t                     nmag4_r;
  lux_t                     dmag4_r;
  brt_t                     smag4_r;
  res_tag_t                 tag4_r;
  logic [PROD_W-1:0]        prod5_r;
  lux_t                     den5_r;
  res_tag_t                 tag5_r;

  always_comb begin
    if (in_lux < seg_lo(bank[0])) begin
      lux_c = seg_lo(bank[0]);
    end else if (in_lux > seg_hi(bank[NUM_SEGS-1])) begin
      lux_c = seg_hi(bank[NUM_SEGS-1]);
    end else begin
      lux_c = in_lux;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SEGS - 1; i++) begin
      le_c[i] = (lux1_r <= seg_hi(bank[i]));
    end
  end

  always_comb begin
    seg_c = LAST_SEG;
    for (int i = NUM_SEGS - 2; i >= 0; i--) begin
      if (le2_r[i]) begin
        seg_c = seg_idx_t'(i);
      end
    end
    sel_c = bank[seg_c];
    num_c = $signed({1'b0, lux2_r}) - $signed({1'b0, seg_lo(sel_c)});
    den_c = $signed({1'b0, seg_hi(sel_c)}) - $signed({1'b0, seg_lo(sel_c)});
  end

  always_comb begin
    span_c       = $signed({1'b0, bmax3_r}) - $signed({1'b0, bmin3_r});
    nabs_c       = num3_r[DIFF_W-1] ? DIFF_W'(-num3_r) : DIFF_W'(num3_r);
    dabs_c       = den3_r[DIFF_W-1] ? DIFF_W'(-den3_r) : DIFF_W'(den3_r);
    sabs_c       = span_c[SPAN_W-1] ? SPAN_W'(-span_c) : SPAN_W'(span_c);
    tag_c.bmin     = bmin3_r;
    tag_c.bmax     = bmax3_r;
    tag_c.seg      = seg3_r;
    tag_c.zero_den = (den3_r == '0);
    tag_c.neg      = num3_r[DIFF_W-1] ^ den3_r[DIFF_W-1] ^ span_c[SPAN_W-1];
    tag_c.capped   = (seg3_r == LAST_SEG) &&
                     (((den3_r > 0) && (num3_r > den3_r)) ||
                      ((den3_r < 0) && (num3_r < den3_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_take;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lux1_r  <= lux_c;
      lux2_r  <= lux1_r;
      le2_r   <= le_c;
      seg3_r  <= seg_c;
      num3_r  <= num_c;
      den3_r  <= den_c;
      bmin3_r <= seg_bmin(sel_c);
      bmax3_r <= seg_bmax(sel_c);
      nmag4_r <= nabs_c[LUX_WIDTH-1:0];
      dmag4_r <= dabs_c[LUX_WIDTH-1:0];
      smag4_r <= sabs_c[BRT_W-1:0];
      tag4_r  <= tag_c;
      prod5_r <= PROD_W'(nmag4_r) * PROD_W'(smag4_r);
      den5_r  <= dmag4_r;
      tag5_r  <= tag4_r;
    end
  end

  always_comb begin
    front_o.valid = v5_r;
    front_o.num   = prod5_r;
    front_o.den   = den5_r;
    front_o.tag   = tag5_r;
  end

endmodule

`default_nettype wire

>>> hdl/ltb_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// The quotient leaves in the num field of the word. Depends on ltb_pkg.
`default_nettype none

module ltb_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire ltb_pkg::div_word_t din,
  output ltb_pkg::div_word_t      dout
);
  import ltb_pkg::*;

  div_word_t st_r  [PROD_W];
  lux_t      rem_r [PROD_W];
  div_word_t st_in [PROD_W];
  lux_t      rem_in[PROD_W];

  for (genvar k = 0; k < PROD_W; k++) begin : g_stage
    logic [LUX_WIDTH:0] trial;
    logic [LUX_WIDTH:0] diff;
    logic               ge;
    div_word_t          word_nxt;
    lux_t               rem_nxt;

    if (k == 0) begin : g_first
      assign st_in[k]  = din;
      assign rem_in[k] = '0;
    end else begin : g_next
      assign st_in[k]  = st_r[k-1];
      assign rem_in[k] = rem_r[k-1];
    end

    always_comb begin
      trial         = {rem_in[k], st_in[k].num[PROD_W-1]};
      diff          = trial - {1'b0, st_in[k].den};
      ge            = (trial >= {1'b0, st_in[k].den});
      rem_nxt       = ge ? diff[LUX_WIDTH-1:0] : trial[LUX_WIDTH-1:0];
      word_nxt      = st_in[k];
      word_nxt.num  = {st_in[k].num[PROD_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k].valid <= 1'b0;
      end else if (en) begin
        st_r[k]  <= word_nxt;
        rem_r[k] <= rem_nxt;
      end
    end
  end

  assign dout = st_r[PROD_W-1];

endmodule

`default_nettype wire

>>> hdl/ltb_out.sv
// Result assembly and output register with a skid stage.
// Produces the pipeline enable. Depends on ltb_pkg.
`default_nettype none

module ltb_out (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ltb_pkg::div_word_t din,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output ltb_pkg::brt_t           out_brightness,
  output ltb_pkg::seg_idx_t       out_segment,
  output logic                    en
);
  import ltb_pkg::*;

  brt_t     q8;
  brt_t     add;
  brt_t     sum;
  brt_t     lvl;
  logic     take;
  logic     out_free;

  logic     out_v_r,   out_v_nxt;
  brt_t     out_brt_r, out_brt_nxt;
  seg_idx_t out_seg_r, out_seg_nxt;
  logic     skid_v_r,   skid_v_nxt;
  brt_t     skid_brt_r, skid_brt_nxt;
  seg_idx_t skid_seg_r, skid_seg_nxt;

  always_comb begin
    q8  = din.num[BRT_W-1:0];
    add = din.tag.neg ? BRT_W'(-q8) : q8;
    sum = din.tag.bmin + add;
    if (din.tag.zero_den) begin
      lvl = din.tag.bmin;
    end else if (din.tag.capped) begin
      lvl = din.tag.bmax;
    end else begin
      lvl = sum;
    end
    if (lvl == '0) begin
      lvl = BRT_W'(1);
    end
  end

  always_comb begin
    take         = out_v_r && !out_stall;
    out_free     = !out_v_r || take;
    out_v_nxt    = out_v_r;
    out_brt_nxt  = out_brt_r;
    out_seg_nxt  = out_seg_r;
    skid_v_nxt   = skid_v_r;
    skid_brt_nxt = skid_brt_r;
    skid_seg_nxt = skid_seg_r;
    if (skid_v_r) begin
      if (out_free) begin
        out_v_nxt   = 1'b1;
        out_brt_nxt = skid_brt_r;
        out_seg_nxt = skid_seg_r;
        skid_v_nxt  = 1'b0;
      end
    end else if (din.valid) begin
      if (out_free) begin
        out_v_nxt   = 1'b1;
        out_brt_nxt = lvl;
        out_seg_nxt = din.tag.seg;
      end else begin
        skid_v_nxt   = 1'b1;
        skid_brt_nxt = lvl;
        skid_seg_nxt = din.tag.seg;
      end
    end else if (take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_brt_r  <= out_brt_nxt;
    out_seg_r  <= out_seg_nxt;
    skid_brt_r <= skid_brt_nxt;
    skid_seg_r <= skid_seg_nxt;
  end

  assign out_valid      = out_v_r;
  assign out_brightness = out_brt_r;
  assign out_segment    = out_seg_r;
  assign en             = !skid_v_r;

endmodule

`default_nettype wire

>>> hdl/lux_to_brightness_piecewise_map_top.sv
// Top level of the ambient light to display brightness mapper.
// Depends on ltb_pkg, ltb_cfg, ltb_front, ltb_div and ltb_out.
//
// Input channel: in_valid, in_stall and in_lux carry one light reading per
// word. Output channel: out_valid, out_stall, out_brightness and
// out_segment carry one result word per reading, in order.
// The five segment registers are written through cfg_we, cfg_index and
// cfg_wdata; an index above four is ignored. Write them only while no
// reading is in flight.
// A reading passes the front stages, the divider stages and the output
// register in that order before its result appears on the output.
// Throughput is one word per cycle while in_stall is low: the divider retires
// one quotient bit per stage, so it takes a new reading every cycle.
// Reset clears the segment registers to zero and empties the pipeline.
// When the receiver stalls, the output word holds and one more word is
// caught in a skid stage; in_stall then rises, registered, and the whole
// pipeline freezes until the output drains.
`default_nettype none

module lux_to_brightness_piecewise_map_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ltb_pkg::LUX_WIDTH-1:0] in_lux,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ltb_pkg::BRT_W-1:0]          out_brightness,
  output logic [ltb_pkg::SEG_W-1:0]          out_segment,
  input  wire logic                          cfg_we,
  input  wire logic [ltb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ltb_pkg::CFG_W-1:0]     cfg_wdata
);
  import ltb_pkg::*;

  cfg_bank_t bank;
  div_word_t front_w;
  div_word_t div_w;
  logic      en;
  logic      in_take;

  assign in_take  = in_valid && en;
  assign in_stall = !en;

  ltb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .bank      (bank)
  );

  ltb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_take (in_take),
    .in_lux  (in_lux),
    .bank    (bank),
    .front_o (front_w)
  );

  ltb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .din   (front_w),
    .dout  (div_w)
  );

  ltb_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .din            (div_w),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_brightness (out_brightness),
    .out_segment    (out_segment),
    .en             (en)
  );

endmodule

`default_nettype wire

>>> hdl/ltb_chk.sv
// Port-level checker for the lux to brightness block, bound to the top.
// Depends on ltb_pkg and the assertion macro header.
`default_nettype none

`include "lux_to_brightness_piecewise_map_top_assert.svh"

module ltb_chk (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_stall,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic [ltb_pkg::BRT_W-1:0] out_brightness,
  input wire logic [ltb_pkg::SEG_W-1:0] out_segment
);
  import ltb_pkg::*;

  `LTB_ASSERT_NXT(a_out_hold, clk, !rst_n, out_valid && out_stall,
    out_valid && $stable(out_brightness) && $stable(out_segment),
    "stalled output word changed")
  `LTB_ASSERT_IMP(a_brt_floor, clk, !rst_n, out_valid, out_brightness != '0,
    "brightness word below one")
  `LTB_ASSERT_IMP(a_seg_range, clk, !rst_n, out_valid, out_segment <= LAST_SEG,
    "segment word out of range")
  `LTB_ASSERT_NXT(a_reset_empty, clk, 1'b0, !rst_n, !out_valid && !in_stall,
    "pipeline not empty after reset")
  `LTB_ASSERT_IMP(a_stall_cause, clk, !rst_n, in_stall,
    $past(out_valid && out_stall), "input stalled without a stalled output")

endmodule

bind lux_to_brightness_piecewise_map_top ltb_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_brightness (out_brightness),
  .out_segment    (out_segment)
);

`default_nettype wire
